// ----- hw/rtl/set_assoc_cache_lru_lookup_assert.svh -----
// Assertion macros for the set-associative tag lookup block.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_ASSERT_SVH

// Check a property on the rising edge, masked during reset.
`define SACL_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on the rising edge, reset included.
`define SACL_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/sacl_pkg.sv -----
// Shared types and constants for the set-associative tag lookup block.
`timescale 1ns / 1ps
package sacl_pkg;

   localparam int ADDR_W     = 32;
   localparam int TAG_W      = 32;
   localparam int STAMP_W    = 32;
   localparam int COUNT_W    = 32;
   localparam int OFFSET_W   = 5;
   localparam int INDEX_W    = 4;
   localparam int WAYS_W     = 4;
   localparam int IB_EFF_W   = 5;
   localparam int SHAMT_W    = 6;
   localparam int OUT_WAY_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS_USED   = 2'd2;

   typedef struct packed {
      logic               valid;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } line_type;

   typedef struct packed {
      logic hit;
      logic evicted;
   } sel_type;

endpackage

// ----- hw/rtl/set_assoc_cache_lru_lookup.sv -----
// Set-associative tag store with timestamp LRU: top level.
// Each request beat is looked up in order: a read of the whole set row (all ways'
// valid, tag and stamp) from the tag RAM, then a compare that picks the hit, fill
// or victim way, writes the row back and loads the response register.
// The RAM's single read-modify-write per set means no new request is accepted
// until the previous one is written back; a response held by rsp_ready low holds the
// write-back of the following request. After reset the tag RAM is cleared one set
// per cycle, all 2**MAX_SETS_LOG2 sets (1024 by default), with req_ready low.
// Configuration writes must only be made while no request is in flight.
`timescale 1ns / 1ps
module set_assoc_cache_lru_lookup #(
   parameter int MAX_SETS_LOG2 = 10,
   parameter int MAX_WAYS      = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [sacl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sacl_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [sacl_pkg::ADDR_W-1:0]         req_address,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic [sacl_pkg::OUT_WAY_W-1:0]      rsp_way,
   output logic                                rsp_evicted,
   output logic [sacl_pkg::COUNT_W-1:0]        rsp_access_count,
   output logic [sacl_pkg::COUNT_W-1:0]        rsp_miss_count
);
   import sacl_pkg::*;

   localparam int SET_W   = (MAX_SETS_LOG2 > 0) ? MAX_SETS_LOG2 : 1;
   localparam int DEPTH   = 1 << SET_W;
   localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CW      = $clog2(MAX_WAYS + 1);
   localparam int ROW_W   = $bits(line_type) * MAX_WAYS;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_LOOK  = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [SET_W-1:0]    clr_ff, clr_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [INDEX_W-1:0]  index_ff, index_in;
   logic [WAYS_W-1:0]   ways_ff, ways_in;
   logic [STAMP_W-1:0]  now_ff, now_in;
   logic [COUNT_W-1:0]  acc_ff, acc_in;
   logic [COUNT_W-1:0]  miss_ff, miss_in;
   logic [SET_W-1:0]    set_ff, set_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff;
   logic [OUT_WAY_W-1:0] rsp_way_ff;
   logic                rsp_evicted_ff;
   logic [COUNT_W-1:0]  rsp_acc_ff;
   logic [COUNT_W-1:0]  rsp_miss_ff;

   logic [IB_EFF_W-1:0] ib_eff;
   logic [CW-1:0]       ways_eff;
   logic [SET_W-1:0]    idx_mask;
   logic [ADDR_W-1:0]   set_raw;
   logic [SHAMT_W-1:0]  tag_shamt;
   logic                accept;
   logic                commit;
   logic                ram_we;
   logic [SET_W-1:0]    ram_waddr;
   logic [ROW_W-1:0]    ram_wdata;
   logic [ROW_W-1:0]    ram_rdata;
   line_type [MAX_WAYS-1:0] rd_row;
   line_type [MAX_WAYS-1:0] wr_row;
   sel_type             sel;
   logic [WAY_W-1:0]    sel_way;
   logic [WAY_W+OUT_WAY_W-1:0] way_ext;

   always_comb begin
      if (int'(index_ff) > MAX_SETS_LOG2) begin
         ib_eff = IB_EFF_W'(MAX_SETS_LOG2);
      end else begin
         ib_eff = IB_EFF_W'(index_ff);
      end
      if (ways_ff == '0) begin
         ways_eff = CW'(1);
      end else if (int'(ways_ff) > MAX_WAYS) begin
         ways_eff = CW'(MAX_WAYS);
      end else begin
         ways_eff = CW'(ways_ff);
      end
   end

   assign idx_mask  = ~({SET_W{1'b1}} << ib_eff);
   assign set_raw   = req_address >> offset_ff;
   assign tag_shamt = SHAMT_W'(offset_ff) + SHAMT_W'(ib_eff);
   assign set_in    = set_raw[SET_W-1:0] & idx_mask;
   assign tag_in    = req_address >> tag_shamt;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_LOOK) && (!rsp_valid_ff || rsp_ready);

   assign rd_row = ram_rdata;

   sacl_way_sel #(
      .MAX_WAYS (MAX_WAYS)
   ) u_way_sel (
      .row      (rd_row),
      .tag      (tag_ff),
      .ways_eff (ways_eff),
      .sel      (sel),
      .way      (sel_way)
   );

   always_comb begin
      wr_row = rd_row;
      wr_row[sel_way].valid = 1'b1;
      wr_row[sel_way].tag   = tag_ff;
      wr_row[sel_way].stamp = sel.hit ? now_ff : now_ff + STAMP_W'(1);
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = set_ff;
      ram_wdata = wr_row;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else if (commit) begin
         ram_we = 1'b1;
      end
   end

   sacl_ram #(
      .WIDTH (ROW_W),
      .DEPTH (DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (set_in),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + SET_W'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      offset_in = offset_ff;
      index_in  = index_ff;
      ways_in   = ways_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_OFFSET_BITS: offset_in = csr_wdata[OFFSET_W-1:0];
            CSR_INDEX_BITS:  index_in  = csr_wdata[INDEX_W-1:0];
            CSR_WAYS_USED:   ways_in   = csr_wdata[WAYS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign now_in  = commit ? now_ff + STAMP_W'(1) : now_ff;
   assign acc_in  = commit ? acc_ff + COUNT_W'(1) : acc_ff;
   assign miss_in = (commit && !sel.hit) ? miss_ff + COUNT_W'(1) : miss_ff;
   assign way_ext = {{OUT_WAY_W{1'b0}}, sel_way};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         offset_ff    <= '0;
         index_ff     <= '0;
         ways_ff      <= WAYS_W'(1);
         now_ff       <= '0;
         acc_ff       <= '0;
         miss_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         offset_ff    <= offset_in;
         index_ff     <= index_in;
         ways_ff      <= ways_in;
         now_ff       <= now_in;
         acc_ff       <= acc_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= set_in;
         tag_ff <= tag_in;
      end
      if (commit) begin
         rsp_hit_ff     <= sel.hit;
         rsp_way_ff     <= way_ext[OUT_WAY_W-1:0];
         rsp_evicted_ff <= sel.evicted;
         rsp_acc_ff     <= acc_in;
         rsp_miss_ff    <= miss_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_way          = rsp_way_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_access_count = rsp_acc_ff;
   assign rsp_miss_count   = rsp_miss_ff;

   // req_type carries no behavior; keep it observed for the lookup beat only
   logic unused_type;
   assign unused_type = req_type & accept;

`include "set_assoc_cache_lru_lookup_assert.svh"

   `SACL_ASSERT(a_accept_to_look, clock, reset, accept |=> (state_ff == ST_LOOK), "accepted beat did not start a lookup")
   `SACL_ASSERT(a_hit_no_evict, clock, reset, (rsp_valid_ff && rsp_hit_ff) |-> !rsp_evicted_ff, "hit reported with eviction")
   `SACL_ASSERT(a_miss_count, clock, reset, (commit && !sel.hit) |=> (miss_ff == $past(miss_ff) + COUNT_W'(1)), "miss counter did not advance on fill")
   `SACL_ASSERT_ALWAYS(a_no_rw_clash, clock, !(accept && ram_we), "tag RAM read and write in the same cycle")

endmodule

// ----- hw/rtl/sacl_ram.sv -----
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module sacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sacl_way_sel.sv -----
// Tag compare, invalid-way search and LRU victim tree over one set row.
`timescale 1ns / 1ps
module sacl_way_sel #(
   parameter int MAX_WAYS = 8
) (
   input  sacl_pkg::line_type [MAX_WAYS-1:0]                           row,
   input  logic [sacl_pkg::TAG_W-1:0]                                  tag,
   input  logic [$clog2(MAX_WAYS+1)-1:0]                               ways_eff,
   output sacl_pkg::sel_type                                           sel,
   output logic [((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0]          way
);
   import sacl_pkg::*;

   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int LEAVES = 1 << WAY_W;
   localparam int NODES  = 2 * LEAVES - 1;

   logic [MAX_WAYS-1:0] active;
   logic [MAX_WAYS-1:0] match;
   logic [MAX_WAYS-1:0] empty;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    inv_way;

   logic               node_elig  [NODES];
   logic [STAMP_W-1:0] node_stamp [NODES];
   logic [WAY_W-1:0]   node_idx   [NODES];

   always_comb begin
      hit_way = '0;
      inv_way = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         active[i] = (i < int'(ways_eff));
         match[i]  = active[i] && row[i].valid && (row[i].tag == tag);
         empty[i]  = active[i] && !row[i].valid;
      end
      for (int i = MAX_WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_way = WAY_W'(i);
         end
         if (empty[i]) begin
            inv_way = WAY_W'(i);
         end
      end
   end

   // min stamp wins, a tie goes to the right (higher) way
   always_comb begin
      int l;
      int r;
      logic pick_r;
      for (int i = 0; i < LEAVES; i++) begin
         node_elig[LEAVES-1+i]  = 1'b0;
         node_stamp[LEAVES-1+i] = '0;
         node_idx[LEAVES-1+i]   = WAY_W'(i);
      end
      for (int i = 0; i < MAX_WAYS; i++) begin
         node_elig[LEAVES-1+i]  = active[i];
         node_stamp[LEAVES-1+i] = row[i].stamp;
      end
      for (int k = LEAVES - 2; k >= 0; k--) begin
         l = 2 * k + 1;
         r = 2 * k + 2;
         pick_r = node_elig[r] && (!node_elig[l] || (node_stamp[r] <= node_stamp[l]));
         node_elig[k]  = node_elig[l] || node_elig[r];
         node_stamp[k] = pick_r ? node_stamp[r] : node_stamp[l];
         node_idx[k]   = pick_r ? node_idx[r] : node_idx[l];
      end
   end

   always_comb begin
      sel.hit     = |match;
      sel.evicted = !(|match) && !(|empty);
      if (|match) begin
         way = hit_way;
      end else if (|empty) begin
         way = inv_way;
      end else begin
         way = node_idx[0];
      end
   end

endmodule
